/* rtl/core/saq_pkg.sv */
package saq_pkg;

	localparam int unsigned ObjW       = 16;
	localparam int unsigned TimeW      = 32;
	localparam int unsigned OccW       = 7;
	localparam int unsigned DefDepth   = 64;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_POLL   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_POPPED   = 3'd1,
		ST_NOTHING  = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [ObjW-1:0]  object_id;
		logic [TimeW-1:0] fire_time;
		logic [TimeW-1:0] current_time;
	} req_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ObjW-1:0] due_object;
		logic [OccW-1:0] occupancy;
	} rsp_t;

	// classified command handed from the front to the store
	typedef struct packed {
		logic             is_ins;
		logic             is_rem;
		logic             is_poll;
		logic [ObjW-1:0]  obj;
		logic [TimeW-1:0] key;
	} cmd_t;

endpackage

/* rtl/core/saq_front.sv */
module saq_front
	import saq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic push,
	output logic full,
	output cmd_t cmd,
	output logic cmd_valid,
	input  logic cmd_take
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		cls.is_ins  = (req.operation == OP_INSERT);
		cls.is_rem  = (req.operation == OP_REMOVE);
		cls.is_poll = (req.operation == OP_POLL);
		cls.obj     = req.object_id;
		cls.key     = (req.operation == OP_POLL) ? req.current_time : req.fire_time;
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

/* rtl/core/saq_store.sv */
module saq_store
	import saq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = DefDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_take,
	input  logic out_free,
	output logic rsp_valid,
	output rsp_t rsp_data
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		BK_IDLE  = 2'b01,
		BK_APPLY = 2'b10
	} bk_state_t;

	bk_state_t              state_q;
	logic [TimeW-1:0]       time_q [QUEUE_DEPTH];
	logic [ObjW-1:0]        obj_q  [QUEUE_DEPTH];
	logic [CW-1:0]          count_q;
	cmd_t                   cmd_s1;
	logic [QUEUE_DEPTH-1:0] gt_s1;
	logic [QUEUE_DEPTH-1:0] match_s1;
	logic                   due_s1;
	logic                   full_s1;
	logic [QUEUE_DEPTH-1:0] gt_c;
	logic [QUEUE_DEPTH-1:0] match_c;
	logic [QUEUE_DEPTH-1:0] pre;
	logic                   found;
	logic                   ins_do;
	logic                   rem_do;
	logic                   pop_do;
	logic                   apply;
	logic [CW-1:0]          count_nxt;
	logic [2:0]             status_c;

	assign cmd_take = (state_q == BK_IDLE) && cmd_valid && out_free;
	assign apply    = (state_q == BK_APPLY);

	// per-cell compare against the request key and id
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cmp
		logic live;
		assign live       = CW'(i) < count_q;
		assign gt_c[i]    = !(live && (time_q[i] <= cmd.key));
		assign match_c[i] = live && (obj_q[i] == cmd.obj);
		assign pre[i]     = |match_s1[i:0];
	end

	assign found  = |match_s1;
	assign ins_do = apply && cmd_s1.is_ins && !full_s1;
	assign rem_do = apply && cmd_s1.is_rem && found;
	assign pop_do = apply && cmd_s1.is_poll && due_s1;

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1   <= cmd;
			gt_s1    <= gt_c;
			match_s1 <= match_c;
			due_s1   <= (count_q != '0) && (time_q[0] < cmd.key);
			full_s1  <= (count_q == CW'(QUEUE_DEPTH));
		end
	end

	// shifting cell row: insert shifts the tail right, remove and pop shift left
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic first_gt;
		if (i == 0) begin : g_head
			assign first_gt = 1'b1;
		end else begin : g_body
			assign first_gt = !gt_s1[i-1];
		end
		always_ff @(posedge clk) begin
			if (ins_do && gt_s1[i]) begin
				if (first_gt) begin
					time_q[i] <= cmd_s1.key;
					obj_q[i]  <= cmd_s1.obj;
				end else begin
					time_q[i] <= time_q[(i > 0) ? i - 1 : 0];
					obj_q[i]  <= obj_q[(i > 0) ? i - 1 : 0];
				end
			end else if ((rem_do && pre[i]) || pop_do) begin
				if (i < QUEUE_DEPTH - 1) begin
					time_q[i] <= time_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
					obj_q[i]  <= obj_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_comb begin
		count_nxt = count_q;
		status_c  = ST_DONE;
		if (cmd_s1.is_ins) begin
			if (full_s1) begin
				status_c = ST_FULL;
			end else begin
				count_nxt = count_q + CW'(1);
			end
		end else if (cmd_s1.is_rem) begin
			if (found) begin
				count_nxt = count_q - CW'(1);
			end else begin
				status_c = ST_NOTFOUND;
			end
		end else if (cmd_s1.is_poll) begin
			if (due_s1) begin
				count_nxt = count_q - CW'(1);
				status_c  = ST_POPPED;
			end else begin
				status_c = ST_NOTHING;
			end
		end
	end

	assign rsp_valid           = apply;
	assign rsp_data.status     = status_c;
	assign rsp_data.due_object = pop_do ? obj_q[0] : '0;
	assign rsp_data.occupancy  = OccW'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (cmd_take) begin
						state_q <= BK_APPLY;
					end
				end
				BK_APPLY: begin
					count_q <= count_nxt;
					state_q <= BK_IDLE;
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/sorted_alarm_queue_unit.sv */
// Sorted alarm queue: keeps up to QUEUE_DEPTH alarms in a row of cells ordered by
// firing time (equal times first-in first-out) and runs insert, remove-by-id and poll
// requests. A two-entry request queue takes requests while the store works and while
// a result waits to be popped. For each request the store first compares every cell
// against the request and registers the outcome, then shifts the row and writes the
// result. It takes the next request only once it is idle and the result register is
// empty again, so it never starts a request before the last result has been popped.
// Each request gives exactly one result.
module sorted_alarm_queue_unit
	import saq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = DefDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic push,
	output logic full,
	output rsp_t rsp,
	output logic empty,
	input  logic pop
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;
	logic res_valid;
	rsp_t res_data;
	rsp_t rsp_q;
	logic rsp_v_q;

	saq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take)
	);

	saq_store #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.out_free  (!rsp_v_q),
		.rsp_valid (res_valid),
		.rsp_data  (res_data)
	);

	assign rsp   = rsp_q;
	assign empty = !rsp_v_q;

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (res_valid) begin
			rsp_v_q <= 1'b1;
		end else if (pop) begin
			rsp_v_q <= 1'b0;
		end
	end

endmodule
